// ----- sv/kst_pkg.sv -----
// Package for the k-smallest tracker: field widths and default sizes.
// Used by the channel interfaces and the core; depends on nothing else.
package kst_pkg;

	// Width of the candidate value and of the largest held value.
	localparam int VAL_W = 32;
	// Width of the running sum of held values.
	localparam int SUM_W = 36;
	// Width of the count field and of the keep-count write data.
	localparam int CNT_W = 5;
	// Default store depth.
	localparam int MAX_KEEP_DEF = 16;

endpackage

// ----- sv/kst_if.sv -----
// Channel interfaces of the k-smallest tracker: input item and result item.
// Each carries valid, ready and the payload; widths come from kst_pkg.
interface kst_in_if import kst_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;
	logic             restart;

	modport source (output valid, output value, output restart, input ready);
	modport sink (input valid, input value, input restart, output ready);
endinterface

interface kst_out_if import kst_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] held_count;
	logic [VAL_W-1:0] largest_held;
	logic [SUM_W-1:0] held_sum;

	modport source (output valid, output held_count, output largest_held, output held_sum,
		input ready);
	modport sink (input valid, input held_count, input largest_held, input held_sum,
		output ready);
endinterface

// ----- sv/k_smallest_tracker_core.sv -----
// Keeps the keep_count smallest of the values offered, as a max-heap held in a
// synchronous memory with one write port and two read ports. Each item is
// accepted, sifted up or down one heap level per step and then reported by
// loading the result register; a value that is dropped or lands in an empty
// store skips the sift. No new item is accepted until the last one is done.
// The sift walks one level a cycle since each step needs the memory read issued
// in the step before. A result waiting in the output register does not stop
// the next item from being accepted, but that item then waits in the done
// state until the result is taken. Depends on kst_pkg and the interfaces in
// kst_if.sv.
module k_smallest_tracker_core import kst_pkg::*; #(
	parameter int MAX_KEEP = MAX_KEEP_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	kst_in_if.sink           item_in,
	kst_out_if.source        result_out
);

	localparam int CW = $clog2(MAX_KEEP + 1);
	localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int KW = (CW > CNT_W) ? CW : CNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UP   = 3'd1;
	localparam logic [2:0] ST_DN   = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;

	// Heap index to memory address; indices past the store read slot zero.
	function automatic logic [AW-1:0] to_addr(input logic [CW:0] idx);
		logic [AW-1:0] a;
		a = '0;
		if (idx < (CW+1)'(MAX_KEEP)) begin
			a = idx[AW-1:0];
		end
		return a;
	endfunction

	logic [2:0]       state_q, state_d;
	logic [KW-1:0]    keep_q;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [CW-1:0]    pos_q, pos_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [VAL_W-1:0] top_q, top_d;
	logic [SUM_W-1:0] sum_q, sum_d;
	logic             out_valid_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [VAL_W-1:0] out_top_q;
	logic [SUM_W-1:0] out_sum_q;

	logic [VAL_W-1:0] heap_mem [MAX_KEEP];
	logic [VAL_W-1:0] rd_a_q, rd_b_q;
	logic [AW-1:0]    rd_addr_a, rd_addr_b, wr_addr;
	logic             mem_we;
	logic [VAL_W-1:0] wr_data;

	logic [CW-1:0]    eff_cnt, lim, parent;
	logic [SUM_W-1:0] base_sum;
	logic [CW:0]      left, right, pick;
	logic [VAL_W-1:0] pick_val;
	logic             left_ok, right_ok, out_load;

	assign item_in.ready = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || result_out.ready);

	// Effective limit: keep count clamped to the store depth.
	always_comb begin
		lim = CW'(MAX_KEEP);
		if (keep_q < KW'(MAX_KEEP)) begin
			lim = CW'(keep_q);
		end
	end

	// Heap neighbours of the current position.
	always_comb begin
		parent   = (pos_q - CW'(1)) >> 1;
		left     = {pos_q, 1'b1};
		right    = left + (CW+1)'(1);
		left_ok  = left < {1'b0, cnt_q};
		right_ok = right < {1'b0, cnt_q};
		pick     = left;
		pick_val = rd_a_q;
		if (right_ok && (rd_b_q > rd_a_q)) begin
			pick     = right;
			pick_val = rd_b_q;
		end
	end

	// Sequencer: accept, sift up or down one level a cycle, then report.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		val_d     = val_q;
		top_d     = top_q;
		sum_d     = sum_q;
		mem_we    = 1'b0;
		wr_addr   = to_addr({1'b0, pos_q});
		wr_data   = val_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		eff_cnt   = item_in.restart ? '0 : cnt_q;
		base_sum  = item_in.restart ? '0 : sum_q;
		case (state_q)
			ST_IDLE: begin
				if (item_in.valid) begin
					if (eff_cnt < lim) begin
						if (eff_cnt == '0) begin
							// Empty store: the value becomes the root directly.
							mem_we  = 1'b1;
							wr_addr = '0;
							wr_data = item_in.value;
							top_d   = item_in.value;
							cnt_d   = CW'(1);
							sum_d   = SUM_W'(item_in.value);
							state_d = ST_DONE;
						end else begin
							pos_d     = eff_cnt;
							val_d     = item_in.value;
							cnt_d     = eff_cnt + CW'(1);
							sum_d     = base_sum + SUM_W'(item_in.value);
							top_d     = (item_in.value > top_q) ? item_in.value : top_q;
							rd_addr_a = to_addr({1'b0, (eff_cnt - CW'(1)) >> 1});
							state_d   = ST_UP;
						end
					end else if ((eff_cnt != '0) && (item_in.value < top_q)) begin
						// Full store: the smaller value replaces the root.
						sum_d     = base_sum - SUM_W'(top_q) + SUM_W'(item_in.value);
						pos_d     = '0;
						val_d     = item_in.value;
						rd_addr_a = to_addr((CW+1)'(1));
						rd_addr_b = to_addr((CW+1)'(2));
						state_d   = ST_DN;
					end else begin
						cnt_d   = eff_cnt;
						sum_d   = base_sum;
						state_d = ST_DONE;
					end
				end
			end
			ST_UP: begin
				mem_we = 1'b1;
				if ((pos_q != '0) && (rd_a_q < val_q)) begin
					// Parent moves down one level; carry on from the parent.
					wr_data   = rd_a_q;
					pos_d     = parent;
					rd_addr_a = to_addr({1'b0, (parent - CW'(1)) >> 1});
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DN: begin
				mem_we = 1'b1;
				if (left_ok && (pick_val > val_q)) begin
					// Larger child moves up one level; carry on from that child.
					wr_data   = pick_val;
					pos_d     = pick[CW-1:0];
					rd_addr_a = to_addr({pick[CW-1:0], 1'b1});
					rd_addr_b = to_addr({pick[CW-1:0], 1'b1} + (CW+1)'(1));
					if (pos_q == '0) begin
						top_d = pick_val;
					end
				end else begin
					if (pos_q == '0) begin
						top_d = val_q;
					end
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Heap store: one write and two registered reads a cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem[wr_addr] <= wr_data;
		end
		rd_a_q <= heap_mem[rd_addr_a];
		rd_b_q <= heap_mem[rd_addr_b];
	end

	// Control state and keep-count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keep_q      <= KW'(MAX_KEEP);
			cnt_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			if (cfg_we) begin
				keep_q <= KW'(cfg_wdata);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result payload.
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		val_q <= val_d;
		top_q <= top_d;
		if (out_load) begin
			out_cnt_q <= CNT_W'(cnt_q);
			out_top_q <= (cnt_q != '0) ? top_q : '0;
			out_sum_q <= sum_q;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.held_count   = out_cnt_q;
	assign result_out.largest_held = out_top_q;
	assign result_out.held_sum     = out_sum_q;

`ifndef NO_ASSERTIONS
	// The count of held values never passes the store depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_KEEP))
		else $error("held count exceeds store depth");

	// An empty store carries a zero sum once an item has settled.
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && (cnt_q == '0) |-> (sum_q == '0))
		else $error("empty store with non-zero sum");

	// An accepted item always starts work in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.valid && item_in.ready |=> (state_q != ST_IDLE))
		else $error("accepted item left the sequencer idle");

	// A sift never walks outside the filled part of the heap.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP) || (state_q == ST_DN) |-> (pos_q < cnt_q))
		else $error("sift position outside held entries");
`endif

endmodule
